// File: rtl/ketr_pkg.sv
// ----------------------------------------------------------------------------
// ketr_pkg
// Shared types and constants for the key event tracker.
// ----------------------------------------------------------------------------
package ketr_pkg;

    localparam int SLOT_COUNT_DEF = 50;

    // Slot wiring: full rows below this bound, plus columns 4..6 of row 4
    localparam int WIRED_FULL_END = 40;
    localparam int ROW4_FIRST     = 44;
    localparam int ROW4_LAST      = 46;

    localparam logic [3:0] FAIL_LIMIT_RST = 4'd5;

    typedef enum logic [2:0] {
        OP_KEY      = 3'd0,
        OP_OVERFLOW = 3'd1,
        OP_FAIL     = 3'd2,
        OP_ROUND_OK = 3'd3,
        OP_LINK_UP  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CAUSE_KEY        = 2'd0,
        CAUSE_OVERFLOW   = 2'd1,
        CAUSE_DISCONNECT = 2'd2
    } cause_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY_WR,
        ST_SCAN
    } state_t;

endpackage

// File: rtl/key_event_tracker_with_release_top.sv
// ----------------------------------------------------------------------------
// key_event_tracker_with_release_top
// Keypad held-key tracker with forced release on overflow and disconnect.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, opcode, event_byte) takes one item when
// in_valid is high and in_stall low. Output channel (out_valid/out_stall,
// slot, pressed, cause, last) delivers result items; last marks the final
// result of an item.
// Timing: the block takes one item at a time. A key event reads the held
// map on accept and writes it back in ST_KEY_WR once the output register
// is free; the result is registered. A release-all walks the held map one
// slot per cycle while the receiver does not stall, up to the last held
// slot (slot 46 at most, the top wired slot). Status opcodes and ignored
// items give no result. The output register lets a new item be accepted
// while a result still waits. When the receiver stalls, the walk pauses
// on the next held slot. Reset clears the held map (per-entry valid bits),
// the failure count and the link state (disconnected); fail_limit returns
// to 5. The user must write it over the APB port, addresses 0 to 3, only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module key_event_tracker_with_release_top #(
    parameter int SLOT_COUNT = ketr_pkg::SLOT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [7:0]  event_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  slot,
    output logic        pressed,
    output logic [1:0]  cause,
    output logic        last
);

    localparam int ADDR_W = $clog2(SLOT_COUNT);

    logic [3:0]        fail_limit_reg, fail_limit_next;
    logic              sel_limit;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic              mem_rd_data;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic              mem_wr_data;

    assign pready    = 1'b1;
    assign sel_limit = !paddr[2];

    always_comb
    begin
        fail_limit_next = fail_limit_reg;
        if (psel && penable && pwrite && sel_limit)
        begin
            fail_limit_next = pwdata[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_limit_reg <= ketr_pkg::FAIL_LIMIT_RST;
        end
        else
        begin
            fail_limit_reg <= fail_limit_next;
        end
    end

    assign prdata = sel_limit ? {28'd0, fail_limit_reg} : 32'd0;

    ketr_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fail_limit  (fail_limit_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .event_byte  (event_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slot        (slot),
        .pressed     (pressed),
        .cause       (cause),
        .last        (last),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    ketr_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

endmodule

// File: rtl/ketr_mem.sv
// ----------------------------------------------------------------------------
// ketr_mem
// Held-map memory: one bit per slot, registered read, per-entry
// valid bits so that an entry never written reads as released.
// ----------------------------------------------------------------------------
module ketr_mem #(
    parameter int SLOT_COUNT = ketr_pkg::SLOT_COUNT_DEF,
    localparam int ADDR_W    = $clog2(SLOT_COUNT)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data
);

    logic                  mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] vld_reg;
    logic                  q_reg;
    logic                  q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_reg & q_vld_reg;

endmodule

// File: rtl/ketr_ctrl.sv
// ----------------------------------------------------------------------------
// ketr_ctrl
// Sequencer: decodes items, read-modify-writes the held map, walks the map
// for release-all and drives the output register.
// ----------------------------------------------------------------------------
module ketr_ctrl #(
    parameter int SLOT_COUNT = ketr_pkg::SLOT_COUNT_DEF,
    localparam int ADDR_W    = $clog2(SLOT_COUNT),
    localparam int CNT_W     = $clog2(SLOT_COUNT + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [3:0]        fail_limit,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        opcode,
    input  logic [7:0]        event_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [5:0]        slot,
    output logic              pressed,
    output logic [1:0]        cause,
    output logic              last,
    output logic              mem_rd_en,
    output logic [ADDR_W-1:0] mem_rd_addr,
    input  logic              mem_rd_data,
    output logic              mem_wr_en,
    output logic [ADDR_W-1:0] mem_wr_addr,
    output logic              mem_wr_data
);

    ketr_pkg::state_t state_reg, state_next;

    logic              connected_reg, connected_next;
    logic [3:0]        fail_reg, fail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [ADDR_W-1:0] chk_addr_reg, chk_addr_next;
    logic [ADDR_W-1:0] key_addr_reg, key_addr_next;
    logic              key_press_reg, key_press_next;
    logic [1:0]        rel_cause_reg, rel_cause_next;

    logic              out_vld_reg, out_vld_next;
    logic [5:0]        slot_reg, slot_next;
    logic              pressed_reg, pressed_next;
    logic [1:0]        cause_reg, cause_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              out_free;
    logic              load;
    logic [7:0]        key_s;
    logic              key_wired;
    logic [3:0]        fail_inc;
    logic              go_key;
    logic              go_scan;
    logic              scan_hit;
    logic              scan_hold;
    logic              scan_end;

    assign in_stall = (state_reg != ketr_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_vld_reg || !out_stall;

    // key number zero wraps to 255, which fails the wiring test
    assign key_s     = {1'b0, event_byte[6:0]} - 8'd1;
    assign key_wired = (event_byte != 8'd0) && (int'(key_s) < SLOT_COUNT)
                       && ((int'(key_s) < ketr_pkg::WIRED_FULL_END)
                           || ((int'(key_s) >= ketr_pkg::ROW4_FIRST)
                               && (int'(key_s) <= ketr_pkg::ROW4_LAST)));
    assign fail_inc  = fail_reg + 4'd1;

    // item decode, only meaningful while accepting
    always_comb
    begin
        go_key         = 1'b0;
        go_scan        = 1'b0;
        connected_next = connected_reg;
        fail_next      = fail_reg;
        rel_cause_next = rel_cause_reg;
        if (accept)
        begin
            if (!connected_reg)
            begin
                if (opcode == ketr_pkg::OP_LINK_UP)
                begin
                    connected_next = 1'b1;
                    fail_next      = 4'd0;
                end
            end
            else
            begin
                case (opcode)
                    ketr_pkg::OP_KEY:
                    begin
                        go_key = key_wired;
                    end
                    ketr_pkg::OP_OVERFLOW:
                    begin
                        go_scan        = (count_reg != '0);
                        rel_cause_next = ketr_pkg::CAUSE_OVERFLOW;
                    end
                    ketr_pkg::OP_FAIL:
                    begin
                        if (fail_inc >= fail_limit)
                        begin
                            connected_next = 1'b0;
                            fail_next      = 4'd0;
                            go_scan        = (count_reg != '0);
                            rel_cause_next = ketr_pkg::CAUSE_DISCONNECT;
                        end
                        else
                        begin
                            fail_next = fail_inc;
                        end
                    end
                    ketr_pkg::OP_ROUND_OK:
                    begin
                        fail_next = 4'd0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // scan: a hit waits for the output register, read data holds meanwhile
    assign scan_hit  = (state_reg == ketr_pkg::ST_SCAN) && chk_vld_reg && mem_rd_data;
    assign scan_hold = scan_hit && !out_free;
    assign scan_end  = scan_hit && out_free && (count_reg == CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ketr_pkg::ST_IDLE:
            begin
                if (go_key)
                begin
                    state_next = ketr_pkg::ST_KEY_WR;
                end
                else if (go_scan)
                begin
                    state_next = ketr_pkg::ST_SCAN;
                end
            end
            ketr_pkg::ST_KEY_WR:
            begin
                if (out_free)
                begin
                    state_next = ketr_pkg::ST_IDLE;
                end
            end
            ketr_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ketr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ketr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_rd_en      = 1'b0;
        mem_rd_addr    = ADDR_W'(key_s);
        mem_wr_en      = 1'b0;
        mem_wr_addr    = key_addr_reg;
        mem_wr_data    = 1'b0;
        load           = 1'b0;
        slot_next      = slot_reg;
        pressed_next   = pressed_reg;
        cause_next     = cause_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        chk_vld_next   = chk_vld_reg;
        chk_addr_next  = chk_addr_reg;
        key_addr_next  = key_addr_reg;
        key_press_next = key_press_reg;
        case (state_reg)
            ketr_pkg::ST_IDLE:
            begin
                if (go_key)
                begin
                    mem_rd_en      = 1'b1;
                    key_addr_next  = ADDR_W'(key_s);
                    key_press_next = event_byte[7];
                end
                scan_next    = '0;
                chk_vld_next = 1'b0;
            end
            ketr_pkg::ST_KEY_WR:
            begin
                if (out_free)
                begin
                    mem_wr_en    = 1'b1;
                    mem_wr_data  = key_press_reg;
                    load         = 1'b1;
                    slot_next    = 6'(key_addr_reg);
                    pressed_next = key_press_reg;
                    cause_next   = ketr_pkg::CAUSE_KEY;
                    last_next    = 1'b1;
                    if (key_press_reg && !mem_rd_data)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (!key_press_reg && mem_rd_data)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            ketr_pkg::ST_SCAN:
            begin
                if (!scan_hold)
                begin
                    if (scan_hit)
                    begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = chk_addr_reg;
                        mem_wr_data  = 1'b0;
                        load         = 1'b1;
                        slot_next    = 6'(chk_addr_reg);
                        pressed_next = 1'b0;
                        cause_next   = rel_cause_reg;
                        last_next    = (count_reg == CNT_W'(1));
                        count_next   = count_reg - CNT_W'(1);
                    end
                    if (scan_end)
                    begin
                        chk_vld_next = 1'b0;
                    end
                    else
                    begin
                        mem_rd_addr   = scan_reg[ADDR_W-1:0];
                        mem_rd_en     = (int'(scan_reg) < SLOT_COUNT);
                        chk_vld_next  = mem_rd_en;
                        chk_addr_next = scan_reg[ADDR_W-1:0];
                        scan_next     = scan_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ketr_pkg::ST_IDLE;
            connected_reg <= 1'b0;
            fail_reg      <= 4'd0;
            count_reg     <= '0;
            scan_reg      <= '0;
            chk_vld_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            connected_reg <= connected_next;
            fail_reg      <= fail_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            chk_vld_reg   <= chk_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg  <= chk_addr_next;
        key_addr_reg  <= key_addr_next;
        key_press_reg <= key_press_next;
        rel_cause_reg <= rel_cause_next;
        slot_reg      <= slot_next;
        pressed_reg   <= pressed_next;
        cause_reg     <= cause_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_vld_reg;
    assign slot      = slot_reg;
    assign pressed   = pressed_reg;
    assign cause     = cause_reg;
    assign last      = last_reg;

    // held count never exceeds the slot count
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= SLOT_COUNT)
        else $error("held count above slot count");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ketr_pkg::ST_SCAN) |-> (count_reg != '0))
        else $error("scan running with nothing held");

    a_scan_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ketr_pkg::ST_SCAN) && load && last_next)
        |=> (state_reg == ketr_pkg::ST_IDLE))
        else $error("scan continued after final release");

endmodule
